>>> sv/svw_pkg.sv
// svw_pkg: shared types and constants of the sv39 page table map and walk core
// field widths, register indexes, status codes, queue item and walker state types
// no dependencies
package svw_pkg;

  // item field widths
  localparam int VA_W       = 39;
  localparam int PA_W       = 56;
  localparam int FLAGS_W    = 8;
  localparam int PPN_W      = 44;
  localparam int PAGE_BYTES = 4096;
  localparam int OFFSET_W   = $clog2(PAGE_BYTES);
  localparam int IDX_W      = 9;
  localparam int ENTRY_W    = PPN_W + FLAGS_W;
  localparam int STATUS_W   = 3;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PPN_W;
  localparam int USED_W     = 5;
  localparam int ROOT_W     = 4;
  localparam int ASTART_W   = 5;

  localparam logic [USED_W-1:0]   CFG_USED_RST   = 5'd16;
  localparam logic [ASTART_W-1:0] CFG_ASTART_RST = 5'd1;

  // entry flag bits
  localparam logic [FLAGS_W-1:0] FLAG_V = 8'h01;
  localparam logic [FLAGS_W-1:0] FLAG_R = 8'h02;

  // depth of the queue between front and walker
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE,
    CFG_POOL_USED,
    CFG_ROOT_PAGE,
    CFG_ALLOC_START
  } cfg_reg_e;

  typedef enum logic [0:0] {
    MODE_MAP,
    MODE_TRANSLATE
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_VIRT_MISALIGN,
    ST_PHYS_MISALIGN,
    ST_POOL_FULL,
    ST_INVALID_INNER,
    ST_OUTSIDE_POOL
  } status_e;

  typedef enum logic [2:0] {
    WS_CLEAR,
    WS_IDLE,
    WS_READ,
    WS_EVAL,
    WS_DONE
  } walk_state_e;

  typedef struct packed {
    logic [PPN_W-1:0]    pool_base_ppn;
    logic [USED_W-1:0]   pool_pages_used;
    logic [ROOT_W-1:0]   root_page;
    logic [ASTART_W-1:0] alloc_start;
  } cfg_t;

  // classified request as it travels through the queue
  typedef struct packed {
    mode_e              mode;
    logic [VA_W-1:0]    va;
    logic [PPN_W-1:0]   target_ppn;
    logic [FLAGS_W-1:0] flags;
    status_e            pre_status;
  } cmd_t;

endpackage

>>> sv/svw_if.sv
// svw_req_if and svw_rsp_if: valid/ready channels for requests and results
// depends on svw_pkg for field widths
interface svw_req_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [svw_pkg::VA_W-1:0]      vaddr;
  logic [svw_pkg::PA_W-1:0]      paddr;
  logic [svw_pkg::FLAGS_W-1:0]   leaf_flags;

  modport source (output valid, mode, vaddr, paddr, leaf_flags,
                  input ready);
  modport sink   (input valid, mode, vaddr, paddr, leaf_flags,
                  output ready);
endinterface

interface svw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [svw_pkg::STATUS_W-1:0]  status;
  logic [svw_pkg::PA_W-1:0]      result_address;

  modport source (output valid, status, result_address, input ready);
  modport sink   (input valid, status, result_address, output ready);
endinterface

>>> sv/svw_front.sv
// svw_front: request intake, alignment checks and one register stage toward the queue
// depends on svw_pkg and svw_req_if
module svw_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  svw_req_if.sink       req_i,
  input  logic          clearing_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output svw_pkg::cmd_t cmd_o
);
  import svw_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept;
  cmd_t cls;

  // classify the incoming item
  always_comb begin
    cls.mode       = mode_e'(req_i.mode);
    cls.va         = req_i.vaddr;
    cls.target_ppn = req_i.paddr[PA_W-1:OFFSET_W];
    cls.flags      = req_i.leaf_flags;
    cls.pre_status = ST_OK;
    if (cls.mode == MODE_MAP) begin
      if (req_i.vaddr[OFFSET_W-1:0] != '0) begin
        cls.pre_status = ST_VIRT_MISALIGN;
      end else if (req_i.paddr[OFFSET_W-1:0] != '0) begin
        cls.pre_status = ST_PHYS_MISALIGN;
      end
    end
  end

  // stage register, held while the queue is full
  assign req_i.ready = !clearing_i && (!valid_q || cmd_ready_i);
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (valid_q && cmd_ready_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = 1'b1;
      cmd_d   = cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

>>> sv/svw_fifo.sv
// svw_fifo: short queue of classified requests between front and walker
// depends on svw_pkg
module svw_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  svw_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output svw_pkg::cmd_t pop_data_o
);
  import svw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             buf_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = cnt_q != CNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = buf_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/svw_walker.sv
// svw_walker: table pool memory, bump allocator and the multi-level walk sequencer
// depends on svw_pkg and svw_rsp_if
module svw_walker #(
  parameter int POOL_PAGES = 16,
  parameter int LEVELS     = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  svw_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  svw_pkg::cmd_t cmd_i,
  output logic          clearing_o,
  svw_rsp_if.source     rsp_o
);
  import svw_pkg::*;

  localparam int PGW   = $clog2(POOL_PAGES);
  localparam int GW    = $clog2(POOL_PAGES + 1);
  localparam int AW    = PGW + IDX_W;
  localparam int DEPTH = POOL_PAGES * (2 ** IDX_W);
  localparam int EW    = ENTRY_W + GW;
  localparam int LVW   = $clog2(LEVELS);
  localparam int CW    = ((GW > ASTART_W) ? GW : ASTART_W) + 1;
  localparam int VXW   = (OFFSET_W + IDX_W * LEVELS > VA_W) ? OFFSET_W + IDX_W * LEVELS : VA_W;

  // table memory: each word carries the generation of its page when written
  logic [EW-1:0]  table_mem [DEPTH];
  logic [GW-1:0]  gen_mem [POOL_PAGES];
  logic [EW-1:0]  rdata_q;
  logic [GW-1:0]  gen_rd_q;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [EW-1:0]  mem_wdata;
  logic           gen_we;
  logic [PGW-1:0] gen_waddr;
  logic [GW-1:0]  gen_wdata;

  walk_state_e    state_q, state_d;
  cmd_t           cmd_q, cmd_d;
  logic [PGW-1:0] page_q, page_d;
  logic [LVW-1:0] lvl_q, lvl_d;
  logic [GW-1:0]  handed_q, handed_d;
  logic [AW-1:0]  clr_cnt_q, clr_cnt_d;
  status_e        res_status_q, res_status_d;
  logic [PA_W-1:0] res_addr_q, res_addr_d;
  logic           out_valid_q, out_valid_d;
  status_e        out_status_q, out_status_d;
  logic [PA_W-1:0] out_addr_q, out_addr_d;

  logic [VXW-1:0]   va_ext;
  logic [IDX_W-1:0] lvl_idx;
  logic [AW-1:0]    slot_addr;
  logic             hit;
  logic [PPN_W-1:0] e_ppn;
  logic [FLAGS_W-1:0] e_flags;
  logic [CW-1:0]    limit;
  logic             root_ok;
  logic [PPN_W-1:0] loc_idx;
  logic             loc_ok;
  logic [CW-1:0]    next_idx;
  logic             room;
  logic [PGW-1:0]   alloc_page;
  logic [GW-1:0]    new_gen;
  logic [PPN_W-1:0] new_ppn;
  logic             same_page;
  logic             alloc_go;

  // address of the entry for the current level
  assign va_ext    = VXW'(cmd_q.va);
  assign lvl_idx   = va_ext[OFFSET_W + IDX_W * lvl_q +: IDX_W];
  assign slot_addr = {page_q, lvl_idx};

  // entry seen through the page generation: stale words read as zero
  assign hit     = rdata_q[EW-1:ENTRY_W] == gen_rd_q;
  assign e_ppn   = hit ? rdata_q[ENTRY_W-1:FLAGS_W] : '0;
  assign e_flags = hit ? rdata_q[FLAGS_W-1:0] : '0;

  // pool bounds
  assign limit   = (CW'(cfg_i.pool_pages_used) < CW'(POOL_PAGES)) ?
                   CW'(cfg_i.pool_pages_used) : CW'(POOL_PAGES);
  assign root_ok = CW'(cfg_i.root_page) < limit;
  assign loc_idx = e_ppn - cfg_i.pool_base_ppn;
  assign loc_ok  = loc_idx < PPN_W'(limit);

  // bump allocator
  assign next_idx   = CW'(cfg_i.alloc_start) + CW'(handed_q);
  assign room       = next_idx < limit;
  assign alloc_page = next_idx[PGW-1:0];
  assign new_gen    = GW'(handed_q + 1'b1);
  assign new_ppn    = cfg_i.pool_base_ppn + PPN_W'(next_idx);
  assign same_page  = alloc_page == page_q;

  assign cmd_ready_o = state_q == WS_IDLE;
  assign clearing_o  = state_q == WS_CLEAR;

  // walk sequencer
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    page_d       = page_q;
    lvl_d        = lvl_q;
    handed_d     = handed_q;
    clr_cnt_d    = clr_cnt_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    mem_we       = 1'b0;
    mem_waddr    = slot_addr;
    mem_wdata    = '0;
    gen_we       = 1'b0;
    gen_waddr    = alloc_page;
    gen_wdata    = new_gen;
    alloc_go     = 1'b0;

    case (state_q)
      WS_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        gen_we    = 1'b1;
        gen_waddr = clr_cnt_q[AW-1 -: PGW];
        gen_wdata = '0;
        clr_cnt_d = AW'(clr_cnt_q + 1'b1);
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = WS_IDLE;
        end
      end

      WS_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d      = cmd_i;
          page_d     = PGW'(cfg_i.root_page);
          lvl_d      = LVW'(LEVELS - 1);
          res_addr_d = '0;
          if (cmd_i.pre_status != ST_OK) begin
            res_status_d = cmd_i.pre_status;
            state_d      = WS_DONE;
          end else if (!root_ok) begin
            res_status_d = ST_OUTSIDE_POOL;
            state_d      = WS_DONE;
          end else begin
            res_status_d = ST_OK;
            state_d      = WS_READ;
          end
        end
      end

      WS_READ: begin
        state_d = WS_EVAL;
      end

      WS_EVAL: begin
        if (lvl_q == '0) begin
          // leaf level
          state_d = WS_DONE;
          if (cmd_q.mode == MODE_MAP) begin
            mem_we    = 1'b1;
            mem_wdata = {gen_rd_q, cmd_q.target_ppn, cmd_q.flags | FLAG_V | FLAG_R};
          end else begin
            res_addr_d = {e_ppn, cmd_q.va[OFFSET_W-1:0]};
          end
        end else if ((e_flags & FLAG_V) != '0) begin
          // follow a valid inner entry
          if (!loc_ok) begin
            res_status_d = ST_OUTSIDE_POOL;
            state_d      = WS_DONE;
          end else begin
            page_d  = loc_idx[PGW-1:0];
            lvl_d   = LVW'(lvl_q - 1'b1);
            state_d = WS_READ;
          end
        end else if (cmd_q.mode == MODE_TRANSLATE) begin
          res_status_d = ST_INVALID_INNER;
          state_d      = WS_DONE;
        end else if (!room) begin
          res_status_d = ST_POOL_FULL;
          state_d      = WS_DONE;
        end else begin
          // hand out a fresh table and link it into the parent entry
          alloc_go  = 1'b1;
          handed_d  = new_gen;
          gen_we    = 1'b1;
          mem_we    = 1'b1;
          mem_wdata = same_page ? {new_gen, new_ppn, FLAG_V}
                                : {gen_rd_q, new_ppn, e_flags | FLAG_V};
          page_d    = alloc_page;
          lvl_d     = LVW'(lvl_q - 1'b1);
          state_d   = WS_READ;
        end
      end

      WS_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = (res_status_q == ST_OK) ? res_addr_q : '0;
          state_d      = WS_IDLE;
        end
      end

      default: begin
        state_d = WS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= WS_CLEAR;
      handed_q    <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      handed_q    <= handed_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    page_q       <= page_d;
    lvl_q        <= lvl_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  // table and generation memories
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= table_mem[slot_addr];
  end

  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    gen_rd_q <= gen_mem[page_q];
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.result_address = out_addr_q;

  // allocation count stays within the pool
  a_handed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    handed_q <= GW'(POOL_PAGES))
    else $error("allocation count beyond pool size");

  // each allocation advances the count by exactly one
  a_alloc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == WS_EVAL && alloc_go) |=> handed_q == GW'($past(handed_q) + 1'b1))
    else $error("allocation count did not advance");

  // the leaf level always ends the walk
  a_leaf_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == WS_EVAL && lvl_q == '0) |=> state_q == WS_DONE)
    else $error("walk continued past the leaf level");

  // no result while the pool is being cleared
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == WS_CLEAR |-> !out_valid_q && !cmd_ready_o)
    else $error("activity during clearing pass");

endmodule

>>> sv/sv39_page_table_map_and_walk_core.sv
// sv39_page_table_map_and_walk_core: top level with configuration registers
// depends on svw_pkg, svw_if, svw_front, svw_fifo, svw_walker
//
// usage
// - req_i carries map (mode 0) and translate (mode 1) requests, rsp_o returns
//   one status and result address per request, in order; both are valid/ready
// - configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i by
//   the user only while no request is in flight, which the block leaves to
//   the user: 0 pool base ppn, 1 pool pages, 2 root page, 3 allocator start
// - a request passes the intake register and a two-entry queue, then the
//   walker takes it in its idle state, reads and then evaluates (possibly
//   writing) the entry at each table level, and hands the result to the
//   output register in its done state; an alignment or root error goes
//   straight from idle to done
// - throughput is one item per walk, as the walker takes a new item only in
//   its idle state and the table reads form a dependent chain across levels
// - after reset the walker clears the table memory one word a cycle, all
//   POOL_PAGES*512 words; req_i.ready stays low meanwhile
// - while rsp_o is stalled the intake and queue keep taking up to three items
module sv39_page_table_map_and_walk_core #(
  parameter int POOL_PAGES = 16,
  parameter int LEVELS     = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [svw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [svw_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  svw_req_if.sink                        req_i,
  svw_rsp_if.source                      rsp_o
);
  import svw_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic clearing;
  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic queue_valid, queue_ready;
  cmd_t queue_cmd;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_POOL_BASE:   cfg_d.pool_base_ppn   = cfg_wdata_i;
        CFG_POOL_USED:   cfg_d.pool_pages_used = cfg_wdata_i[USED_W-1:0];
        CFG_ROOT_PAGE:   cfg_d.root_page       = cfg_wdata_i[ROOT_W-1:0];
        CFG_ALLOC_START: cfg_d.alloc_start     = cfg_wdata_i[ASTART_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_base_ppn   <= '0;
      cfg_q.pool_pages_used <= CFG_USED_RST;
      cfg_q.root_page       <= '0;
      cfg_q.alloc_start     <= CFG_ASTART_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  svw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .clearing_i (clearing),
    .cmd_valid_o(front_valid),
    .cmd_ready_i(front_ready),
    .cmd_o      (front_cmd)
  );

  svw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .push_data_i (front_cmd),
    .pop_valid_o (queue_valid),
    .pop_ready_i (queue_ready),
    .pop_data_o  (queue_cmd)
  );

  svw_walker #(
    .POOL_PAGES(POOL_PAGES),
    .LEVELS    (LEVELS)
  ) u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(queue_valid),
    .cmd_ready_o(queue_ready),
    .cmd_i      (queue_cmd),
    .clearing_o (clearing),
    .rsp_o      (rsp_o)
  );

endmodule

>>> tb/testbench.sv
// testbench for the sv39 page table map and walk core: map and translate items against
// an in-bench prediction of the table pool, over several register settings
// depends on svw_pkg, svw_req_if, svw_rsp_if and sv39_page_table_map_and_walk_core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import svw_pkg::*;

  localparam int POOL_PAGES  = 16;
  localparam int LEVELS      = 3;
  localparam int ENTRIES     = 512;
  localparam int NUM_PHASES  = 9;
  localparam int PHASE_ITEMS = 220;
  localparam int SETTLE_CYC  = 24;

  // prediction of the table pool and ordered store of due results
  class walk_scoreboard;
    typedef struct {
      status_e         st;
      logic [PA_W-1:0] addr;
    } walk_result_t;

    bit [ENTRY_W-1:0] pt_mem [POOL_PAGES*ENTRIES];
    int unsigned      alloc_count = 0;
    bit [PPN_W-1:0]   base_ppn    = '0;
    int unsigned      pool_size   = 16;
    int unsigned      root_idx    = 0;
    int unsigned      alloc_first = 1;
    walk_result_t     results_due [$];
    int unsigned      mismatches  = 0;
    int unsigned      n_map       = 0;
    int unsigned      n_translate = 0;
    int unsigned      status_seen [6];

    function void set_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] v);
      case (r)
        CFG_POOL_BASE:   base_ppn    = v;
        CFG_POOL_USED:   pool_size   = v[USED_W-1:0];
        CFG_ROOT_PAGE:   root_idx    = v[ROOT_W-1:0];
        CFG_ALLOC_START: alloc_first = v[ASTART_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned usable_pages();
      return (pool_size < POOL_PAGES) ? pool_size : POOL_PAGES;
    endfunction

    function int unsigned vpn(logic [VA_W-1:0] va, int lvl);
      return va[OFFSET_W + IDX_W*lvl +: IDX_W];
    endfunction

    // pool page of a table ppn, relative to the pool base with wrap
    function bit pool_page(bit [PPN_W-1:0] ppn, output int unsigned pg);
      bit [PPN_W-1:0] rel;
      pg  = 0;
      rel = ppn - base_ppn;
      if (rel >= usable_pages()) return 1'b0;
      pg = int'(rel);
      return 1'b1;
    endfunction

    function status_e map_page(logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                               logic [FLAGS_W-1:0] flags);
      int unsigned    pg;
      int unsigned    nxt;
      int unsigned    slot;
      bit [ENTRY_W-1:0] e;
      bit [PPN_W-1:0] ppn;
      if (va[OFFSET_W-1:0] != '0) return ST_VIRT_MISALIGN;
      if (pa[OFFSET_W-1:0] != '0) return ST_PHYS_MISALIGN;
      if (root_idx >= usable_pages()) return ST_OUTSIDE_POOL;
      pg = root_idx;
      for (int lvl = LEVELS-1; lvl > 0; lvl--) begin
        slot = pg*ENTRIES + vpn(va, lvl);
        e    = pt_mem[slot];
        if (!e[0]) begin
          // missing inner table: take the next page, clear it, then link it
          nxt = alloc_first + alloc_count;
          if (nxt >= usable_pages()) return ST_POOL_FULL;
          alloc_count++;
          for (int k = 0; k < ENTRIES; k++) pt_mem[nxt*ENTRIES + k] = '0;
          ppn = base_ppn + PPN_W'(nxt);
          e   = pt_mem[slot];
          pt_mem[slot] = {ppn, e[FLAGS_W-1:0] | FLAG_V};
          pg = nxt;
        end else if (!pool_page(e[ENTRY_W-1:FLAGS_W], pg)) begin
          return ST_OUTSIDE_POOL;
        end
      end
      pt_mem[pg*ENTRIES + vpn(va, 0)] = {pa[PA_W-1:OFFSET_W], flags | FLAG_V | FLAG_R};
      return ST_OK;
    endfunction

    function status_e walk_translate(logic [VA_W-1:0] va, output logic [PA_W-1:0] addr);
      int unsigned      pg;
      bit [ENTRY_W-1:0] e;
      addr = '0;
      if (root_idx >= usable_pages()) return ST_OUTSIDE_POOL;
      pg = root_idx;
      for (int lvl = LEVELS-1; lvl > 0; lvl--) begin
        e = pt_mem[pg*ENTRIES + vpn(va, lvl)];
        if (!e[0]) return ST_INVALID_INNER;
        if (!pool_page(e[ENTRY_W-1:FLAGS_W], pg)) return ST_OUTSIDE_POOL;
      end
      // leaf valid bit is not looked at
      e    = pt_mem[pg*ENTRIES + vpn(va, 0)];
      addr = {e[ENTRY_W-1:FLAGS_W], va[OFFSET_W-1:0]};
      return ST_OK;
    endfunction

    function void note_request(mode_e m, logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                               logic [FLAGS_W-1:0] flags);
      walk_result_t    r;
      logic [PA_W-1:0] addr;
      if (m == MODE_MAP) begin
        r.st = map_page(va, pa, flags);
        addr = '0;
        n_map++;
      end else begin
        r.st = walk_translate(va, addr);
        n_translate++;
      end
      r.addr = (r.st == ST_OK) ? addr : '0;
      status_seen[r.st]++;
      results_due.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [PA_W-1:0] addr);
      walk_result_t r;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no item pending: status %0d address %h", $time, st, addr);
        return;
      end
      r = results_due.pop_front();
      if (st !== r.st || addr !== r.addr) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: status expected %0d got %0d, address expected %h got %h",
                   $time, r.st, st, r.addr, addr);
      end
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction

    function int unsigned failures();
      return mismatches + results_due.size();
    endfunction

    function void summary(int phases);
      string s;
      $display("run covered %0d maps, %0d translates, %0d settings, %0d pages allocated",
               n_map, n_translate, phases + 1, alloc_count);
      s = $sformatf("statuses: ok %0d, virt misaligned %0d, phys misaligned %0d,",
                    status_seen[ST_OK], status_seen[ST_VIRT_MISALIGN],
                    status_seen[ST_PHYS_MISALIGN]);
      $display("%s pool full %0d, invalid inner %0d, outside pool %0d", s,
               status_seen[ST_POOL_FULL], status_seen[ST_INVALID_INNER],
               status_seen[ST_OUTSIDE_POOL]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  svw_req_if req_ch ();
  svw_rsp_if rsp_ch ();

  walk_scoreboard  sb = new;
  bit              steady        = 1'b0;
  bit              hold_request  = 1'b0;
  int              tx_burst_left = 0;
  logic [VA_W-1:0] mapped_va [$];

  sv39_page_table_map_and_walk_core DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls, steady stretches and a long hold on request
  initial begin
    int stall_left;
    int hold_left;
    int r;
    stall_left = 0;
    hold_left  = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = 400;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (steady) begin
        rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          rsp_ch.ready <= 1'b1;
        end else if (r < 92) begin
          stall_left = $urandom_range(0, 2);
          rsp_ch.ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(10, 50);
          rsp_ch.ready <= 1'b0;
        end
      end
    end
  end

  // result check at the rising edge
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready)
      sb.check_result(rsp_ch.status, rsp_ch.result_address);
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one item and keep it until accepted, then maybe idle
  task automatic send_request(mode_e m, logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                              logic [FLAGS_W-1:0] flags);
    int gap;
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= m;
    req_ch.vaddr      <= va;
    req_ch.paddr      <= pa;
    req_ch.leaf_flags <= flags;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(m, va, pa, flags);
    if (tx_burst_left > 0) begin
      tx_burst_left--;
      gap = 0;
    end else begin
      gap = steady ? 0 : idle_length();
    end
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= r;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(r, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(logic [CFG_DATA_W-1:0] base, int unsigned used,
                              int unsigned root, int unsigned first);
    write_reg(CFG_POOL_BASE, base);
    write_reg(CFG_POOL_USED, CFG_DATA_W'(used));
    write_reg(CFG_ROOT_PAGE, CFG_DATA_W'(root));
    write_reg(CFG_ALLOC_START, CFG_DATA_W'(first));
  endtask

  // stop offering and wait for every due result
  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_idle();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // table indices bunched on a few values so that tables get reused
  function automatic logic [IDX_W-1:0] pick_index(int lvl);
    int r;
    r = $urandom_range(0, 9);
    if (r >= 8) return IDX_W'($urandom);
    if (lvl == 0) return (r < 7) ? IDX_W'($urandom_range(0, 7)) : '1;
    if (r < 4) return '0;
    if (r < 6) return IDX_W'(1);
    if (lvl == 2 && r == 6) return IDX_W'(2);
    return '1;
  endfunction

  function automatic logic [VA_W-1:0] pick_va(bit aligned);
    logic [OFFSET_W-1:0] off;
    off = aligned ? '0 : OFFSET_W'($urandom);
    return {pick_index(2), pick_index(1), pick_index(0), off};
  endfunction

  // target is often a pool page, so leaves can later serve as tables
  function automatic logic [PA_W-1:0] pick_pa();
    logic [PPN_W-1:0] ppn;
    if ($urandom_range(0, 1)) ppn = sb.base_ppn + PPN_W'($urandom_range(0, 17));
    else ppn = PPN_W'({$urandom(), $urandom()});
    return {ppn, {OFFSET_W{1'b0}}};
  endfunction

  task automatic random_request();
    int                 r;
    mode_e              m;
    logic [VA_W-1:0]    va;
    logic [VA_W-1:0]    seen;
    logic [PA_W-1:0]    pa;
    logic [FLAGS_W-1:0] flags;
    r     = $urandom_range(0, 99);
    flags = FLAGS_W'($urandom);
    pa    = pick_pa();
    if (r < 45) begin
      m  = MODE_MAP;
      va = pick_va(1'b1);
      mapped_va.push_back(va);
      if (mapped_va.size() > 32) void'(mapped_va.pop_front());
    end else if (r < 88) begin
      m = MODE_TRANSLATE;
      if (mapped_va.size() > 0 && $urandom_range(0, 4) != 0) begin
        seen = mapped_va[$urandom_range(0, mapped_va.size() - 1)];
        va   = {seen[VA_W-1:OFFSET_W], OFFSET_W'($urandom)};
      end else begin
        va = pick_va(1'b0);
      end
    end else begin
      // noise: any mode, any address, mostly misaligned
      m  = mode_e'($urandom_range(0, 1));
      va = VA_W'({$urandom(), $urandom()});
      pa = PA_W'({$urandom(), $urandom()});
    end
    send_request(m, va, pa, flags);
  endtask

  // field extremes, every status and the special walk cases
  task automatic run_directed();
    send_request(MODE_TRANSLATE, '0, '0, '0);
    send_request(MODE_MAP, VA_W'('h1001), '0, 8'h00);
    send_request(MODE_MAP, '0, PA_W'(1), 8'h00);
    // both misaligned: virtual wins
    send_request(MODE_MAP, VA_W'('hfff), PA_W'('h800), 8'h00);
    send_request(MODE_MAP, '0, '0, 8'h00);
    send_request(MODE_TRANSLATE, VA_W'('hfff), '0, '0);
    send_request(MODE_MAP, {{3{9'h1ff}}, 12'h000}, {44'hfff_ffff_ffff, 12'h000}, 8'hff);
    send_request(MODE_TRANSLATE, '1, '1, '1);
    // leaf never written inside an existing table
    send_request(MODE_TRANSLATE, {{2{9'h1ff}}, 9'h1fe, 12'h123}, '0, '0);
    send_request(MODE_TRANSLATE, {9'h100, 18'd0, 12'h000}, '0, '0);
    // leaf that points at a pool page
    send_request(MODE_MAP, {27'd1, 12'h000}, {44'd3, 12'h000}, 8'h0e);
    send_request(MODE_MAP, {27'd2, 12'h000}, 56'h55_5555_5555_5000, 8'h55);
    send_request(MODE_MAP, {27'd3, 12'h000}, 56'haa_aaaa_aaaa_a000, 8'haa);
    send_request(MODE_TRANSLATE, {27'd2, 12'hfff}, '0, '0);

    // root on a leaf table: valid leaves with R set are walked as inner entries
    drain();
    write_reg(CFG_ROOT_PAGE, CFG_DATA_W'(2));
    send_request(MODE_TRANSLATE, {9'd1, 9'h1ff, 9'h1ff, 12'habc}, '0, '0);
    send_request(MODE_MAP, {9'd3, 18'd0, 12'h000}, {44'd7, 12'h000}, 8'h00);
    send_request(MODE_MAP, {9'd9, 18'd5, 12'h000}, {44'd8, 12'h000}, 8'h00);

    // small pool: followed tables outside, allocation out of pages
    drain();
    write_reg(CFG_ROOT_PAGE, '0);
    write_reg(CFG_POOL_USED, CFG_DATA_W'(2));
    send_request(MODE_TRANSLATE, '0, '0, '0);
    send_request(MODE_MAP, {9'h100, 18'd0, 12'h000}, '0, 8'h00);

    // root outside the pool
    drain();
    write_reg(CFG_ROOT_PAGE, CFG_DATA_W'(15));
    send_request(MODE_TRANSLATE, '0, '0, '0);
    send_request(MODE_MAP, '0, '0, 8'h00);

    // allocator starting past the pool
    drain();
    write_reg(CFG_POOL_USED, CFG_DATA_W'(16));
    write_reg(CFG_ROOT_PAGE, '0);
    write_reg(CFG_ALLOC_START, CFG_DATA_W'(16));
    send_request(MODE_MAP, {9'd7, 18'd0, 12'h000}, '0, 8'h00);
  endtask

  // stimulus
  initial begin
    logic [CFG_DATA_W-1:0] base;
    int unsigned           used;
    int unsigned           root;
    int unsigned           first;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_POOL_BASE;
    cfg_wdata         <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.mode       <= MODE_MAP;
    req_ch.vaddr      <= '0;
    req_ch.paddr      <= '0;
    req_ch.leaf_flags <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    apply_config('0, 16, 0, 1);
    run_directed();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin base = '0; used = 16; root = 0;  first = 1;  end
        1: begin base = '0; used = 31; root = 0;  first = 0;  end
        2: begin base = '1; used = 16; root = 15; first = 16; end
        3: begin base = '0; used = 1;  root = 0;  first = 0;  end
        4: begin base = '0; used = 0;  root = 0;  first = 1;  end
        default: begin
          case ($urandom_range(0, 19))
            0, 1, 2:    base = '1;
            3, 4, 5:    base = CFG_DATA_W'($urandom_range(1, 40));
            default:    base = '0;
          endcase
          used  = ($urandom_range(0, 99) < 65) ? 16 : $urandom_range(0, 31);
          root  = ($urandom_range(0, 99) < 60) ? 0 : $urandom_range(0, 15);
          first = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 4) : $urandom_range(0, 31);
        end
      endcase
      drain();
      apply_config(base, used, root, first);
      steady = (p == 3 || p == 6);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long hold on results while items keep coming back to back
        if (p == 0 && i == 20) begin
          hold_request  = 1'b1;
          tx_burst_left = 40;
        end
        if (p == 1 && i == 110) wait_idle();
        random_request();
      end
    end

    drain();
    sb.summary(NUM_PHASES);
    if (sb.failures() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/svw_pkg.sv
sv/svw_if.sv
sv/svw_front.sv
sv/svw_fifo.sv
sv/svw_walker.sv
sv/sv39_page_table_map_and_walk_core.sv
tb/testbench.sv
